[src/ffba_pkg.sv]
// Shared types and constants of the first-fit block allocator.
// Depends on nothing; imported by the allocator and the checker.
package ffba_pkg;

    localparam int unsigned POOL_BYTES_DEF   = 1024 * 1024;
    localparam int unsigned HEADER_BYTES_DEF = 12;
    localparam int unsigned MAX_BLOCKS_DEF   = 256;

    localparam int unsigned ADDR_W  = 21;
    localparam int unsigned START_W = 20;
    localparam int unsigned LINK_W  = 8;
    localparam int unsigned STAT_W  = 2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFND  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NULLREL = 2'd3;

    // request kinds
    localparam logic FN_ALLOC   = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    // one slot table entry
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [ADDR_W-1:0]  length;
        logic [LINK_W-1:0]  link;
        logic               is_last;
        logic               is_free;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

[src/ffba_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ffba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/first_fit_block_allocator.sv]
// First-fit allocator over a byte pool: request FSM around one slot-table RAM.
// Depends on ffba_pkg and ffba_ram.
//
// One request is worked at a time. Each chain step is a RAM read (S_RD) plus a
// check (S_CHK). An allocate that splits a block then scans the used-slot bits
// for a spare slot (S_SCAN) and writes the new and the split entries (S_SPLIT1,
// S_SPLIT2). After reset, the S_INIT state sets up the head block before the
// first request is taken. A finished result sits in an output register so the
// next request can be taken while it waits.
module first_fit_block_allocator #(
    parameter int unsigned POOL_BYTES   = ffba_pkg::POOL_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // req_size[20:0], req_addr[41:21], zero pad
    input  logic        i_s_axis_tuser,  // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // result_addr[20:0], status[22:21], zero pad
);
    import ffba_pkg::*;

    localparam int unsigned SW = $clog2(MAX_BLOCKS);
    localparam logic [ADDR_W:0] HDR = (ADDR_W+1)'(HEADER_BYTES);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_CHK, S_SCAN, S_SPLIT1, S_SPLIT2,
        S_RDN, S_CHKN, S_MERGE, S_FIN
    } t_state;

    t_state              r_state;
    logic                r_func;
    logic [ADDR_W-1:0]   r_size, r_addr;
    logic [SW-1:0]       r_cur, r_prev, r_scan, r_nx;
    logic                r_prev_ok;
    t_entry              r_ent, r_pent;
    logic [MAX_BLOCKS-1:0] r_used;
    logic [ADDR_W-1:0]   r_fin_addr, r_out_addr;
    logic [STAT_W-1:0]   r_fin_stat, r_out_stat;
    logic                r_ovalid;

    logic                w_we;
    logic [SW-1:0]       w_waddr, w_raddr;
    t_entry              w_wdata, w_q;
    logic [ENTRY_W-1:0]  w_q_raw;

    ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_slots (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_q_raw)
    );
    assign w_q = t_entry'(w_q_raw);

    // derived values of the entry just read
    logic [ADDR_W:0] w_q_data;      // data offset of read entry
    logic [ADDR_W:0] w_size_h;      // request plus one header
    logic            w_fits, w_split, w_hit;
    assign w_q_data = (ADDR_W+1)'(w_q.start) + HDR;
    assign w_size_h = (ADDR_W+1)'(r_size) + HDR;
    assign w_fits   = w_q.is_free && (w_q.length >= r_size);
    assign w_split  = (ADDR_W+1)'(w_q.length) > w_size_h;
    assign w_hit    = (w_q_data == (ADDR_W+1)'(r_addr));

    // merged, split and freed entries
    t_entry w_cur_abs, w_prev_abs, w_new, w_cur_split, w_q_freed;
    always_comb begin
        w_cur_abs        = r_ent;
        w_cur_abs.length = ADDR_W'((ADDR_W+1)'(r_ent.length) + HDR
                                   + (ADDR_W+1)'(w_q.length));
        w_cur_abs.link    = w_q.link;
        w_cur_abs.is_last = w_q.is_last;
        w_cur_abs.is_free = 1'b1;

        w_prev_abs        = r_pent;
        w_prev_abs.length = ADDR_W'((ADDR_W+1)'(r_pent.length) + HDR
                                    + (ADDR_W+1)'(r_ent.length));
        w_prev_abs.link    = r_ent.link;
        w_prev_abs.is_last = r_ent.is_last;

        w_new.start   = START_W'((ADDR_W+1)'(r_ent.start) + w_size_h);
        w_new.length  = ADDR_W'((ADDR_W+1)'(r_ent.length) - w_size_h);
        w_new.link    = r_ent.link;
        w_new.is_last = r_ent.is_last;
        w_new.is_free = 1'b1;

        w_cur_split         = r_ent;
        w_cur_split.length  = r_size;
        w_cur_split.link    = LINK_W'(r_scan);
        w_cur_split.is_last = 1'b0;
        w_cur_split.is_free = 1'b0;

        // released block, marked free
        w_q_freed         = w_q;
        w_q_freed.is_free = 1'b1;
    end

    // RAM port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = r_ent;
        w_raddr = r_cur;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata.start   = '0;
                w_wdata.length  = ADDR_W'(POOL_BYTES - HEADER_BYTES);
                w_wdata.link    = '0;
                w_wdata.is_last = 1'b1;
                w_wdata.is_free = 1'b1;
            end
            S_RDN: w_raddr = r_nx;
            S_SCAN: begin
                // no spare slot: hand the block out whole
                if (r_used[r_scan] && r_scan == SW'(MAX_BLOCKS - 1)) begin
                    w_we = 1'b1;
                    w_wdata.is_free = 1'b0;
                end
            end
            S_SPLIT1: begin
                w_we    = 1'b1;
                w_waddr = r_scan;
                w_wdata = w_new;
            end
            S_SPLIT2: begin
                w_we    = 1'b1;
                w_wdata = w_cur_split;
            end
            S_CHK: begin
                // fitting block needing no split
                if (r_func == FN_ALLOC && w_fits && !w_split) begin
                    w_we    = 1'b1;
                    w_wdata = w_q;
                    w_wdata.is_free = 1'b0;
                end
            end
            S_MERGE: begin
                w_we = 1'b1;
                if (r_prev_ok && r_pent.is_free) begin
                    w_waddr = r_prev;
                    w_wdata = w_prev_abs;
                end
            end
            default: ;
        endcase
    end

    // request sequencer, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_used   <= MAX_BLOCKS'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_func    <= i_s_axis_tuser;
                        r_size    <= i_s_axis_tdata[20:0];
                        r_addr    <= i_s_axis_tdata[41:21];
                        r_cur     <= '0;
                        r_prev_ok <= 1'b0;
                        if (i_s_axis_tuser == FN_RELEASE && i_s_axis_tdata[41:21] == '0) begin
                            r_fin_addr <= '0;
                            r_fin_stat <= ST_NULLREL;
                            r_state    <= S_FIN;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    r_ent <= (r_func == FN_RELEASE && w_hit) ? w_q_freed : w_q;
                    if (r_func == FN_ALLOC) begin
                        if (w_fits) begin
                            r_fin_addr <= ADDR_W'(w_q_data);
                            r_fin_stat <= ST_DONE;
                            r_scan     <= '0;
                            r_state    <= w_split ? S_SCAN : S_FIN;
                        end else if (w_q.is_last) begin
                            r_fin_addr <= '0;
                            r_fin_stat <= ST_NOFIT;
                            r_state    <= S_FIN;
                        end else begin
                            r_cur   <= SW'(w_q.link);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_fin_addr <= '0;
                        if (w_hit) begin
                            r_fin_stat    <= ST_DONE;
                            r_nx          <= SW'(w_q.link);
                            r_state       <= w_q.is_last ? S_MERGE : S_RDN;
                        end else if (w_q.is_last) begin
                            r_fin_stat <= ST_NOTFND;
                            r_state    <= S_FIN;
                        end else begin
                            r_prev    <= r_cur;
                            r_pent    <= w_q;
                            r_prev_ok <= 1'b1;
                            r_cur     <= SW'(w_q.link);
                            r_state   <= S_RD;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_used[r_scan]) begin
                        r_used[r_scan] <= 1'b1;
                        r_state        <= S_SPLIT1;
                    end else if (r_scan == SW'(MAX_BLOCKS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_SPLIT1: r_state <= S_SPLIT2;
                S_SPLIT2: r_state <= S_FIN;
                S_RDN: r_state <= S_CHKN;
                S_CHKN: begin
                    // free successor folds into this block
                    if (w_q.is_free) begin
                        r_ent        <= w_cur_abs;
                        r_used[r_nx] <= 1'b0;
                    end
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    if (r_prev_ok && r_pent.is_free) begin
                        r_used[r_cur] <= 1'b0;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_out_addr <= r_fin_addr;
                        r_out_stat <= r_fin_stat;
                        r_ovalid   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_out_stat, r_out_addr};
endmodule

[src/ffba_checker.sv]
// Port-level checks for the first-fit block allocator, bound to the top level.
// Depends on the top level's ports and on ffba_pkg for the status codes.
module ffba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);
    import ffba_pkg::*;

    // result transaction holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // one request at a time: busy right after an accepted transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while another in work");

    // nothing offered right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered after reset");

    // a failed or ignored request returns no address
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[22:21] != ST_DONE |-> o_m_axis_tdata[20:0] == '0)
        else $error("nonzero address with failure status");
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);
